// File: design/csc_pkg.sv
// Shared types and constants for the column slide compactor.
// No dependencies; imported by csc_engine and column_slide_compactor.
package csc_pkg;

  localparam int MaxColumnsDef = 256;
  localparam int MaxRowsDef    = 64;
  localparam int RowIdxW       = 6;
  localparam int OutColW       = 8;
  localparam int StatusW       = 2;

  localparam logic [StatusW-1:0] StatusPlaced   = 2'd0;
  localparam logic [StatusW-1:0] StatusReversed = 2'd1;
  localparam logic [StatusW-1:0] StatusCapacity = 2'd2;

  typedef struct packed {
    logic [OutColW-1:0] source_column;
    logic [OutColW-1:0] target_column;
    logic [OutColW-1:0] shift_cols;
    logic [StatusW-1:0] status;
  } csc_result_t;

endpackage

// File: design/csc_engine.sv
// Placement engine: occupancy memory, column counter and the leftward walk.
// Depends on csc_pkg; instantiated by column_slide_compactor.
module csc_engine #(
  parameter int MAX_COLUMNS = csc_pkg::MaxColumnsDef,
  parameter int MAX_ROWS    = csc_pkg::MaxRowsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         first_column_i,
  input  logic [csc_pkg::RowIdxW-1:0]  min_row_i,
  input  logic [csc_pkg::RowIdxW-1:0]  max_row_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output csc_pkg::csc_result_t         res_o
);
  import csc_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int AW = $clog2(MAX_COLUMNS);
  localparam logic [CW-1:0] CapCount = CW'(MAX_COLUMNS);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [MAX_ROWS-1:0] mem [MAX_COLUMNS];
  logic [MAX_ROWS-1:0] rdata_q;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       src_q, src_d;
  logic [CW-1:0]       tgt_q, tgt_d;
  logic [MAX_ROWS-1:0] bits_q, bits_d;
  logic [MAX_ROWS-1:0] acc_q, acc_d;
  logic [StatusW-1:0]  status_q, status_d;

  logic                we_c, re_c;
  logic [AW-1:0]       wa_c, ra_c;
  logic [MAX_ROWS-1:0] wd_c;
  logic [MAX_ROWS-1:0] bits_c;
  logic [CW-1:0]       src_c;
  logic [CW-1:0]       tgt_m1, tgt_m2;
  logic [CW-1:0]       src_m1;
  logic                accept;
  logic [CW+OutColW-1:0] src_ext, tgt_ext, shift_ext;

  always_comb begin
    for (int j = 0; j < MAX_ROWS; j++) begin
      bits_c[j] = (RowIdxW'(j) >= min_row_i) && (RowIdxW'(j) <= max_row_i);
    end
  end

  assign accept = in_valid_i && (state_q == StIdle);
  assign src_c  = first_column_i ? '0 : cnt_q;
  assign src_m1 = src_c - CW'(1);
  assign tgt_m1 = tgt_q - CW'(1);
  assign tgt_m2 = tgt_q - CW'(2);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    src_d    = src_q;
    tgt_d    = tgt_q;
    bits_d   = bits_q;
    acc_d    = acc_q;
    status_d = status_q;
    we_c     = 1'b0;
    wa_c     = src_c[AW-1:0];
    wd_c     = '0;
    re_c     = 1'b0;
    ra_c     = src_m1[AW-1:0];
    case (state_q)
      StIdle: begin
        if (accept) begin
          src_d  = src_c;
          tgt_d  = src_c;
          bits_d = bits_c;
          acc_d  = '0;
          if (src_c == CapCount) begin
            status_d = StatusCapacity;
            cnt_d    = src_c;
            state_d  = StDone;
          end else if (min_row_i > max_row_i) begin
            // column is consumed but left empty
            status_d = StatusReversed;
            cnt_d    = src_c + CW'(1);
            we_c     = 1'b1;
            state_d  = StDone;
          end else begin
            status_d = StatusPlaced;
            cnt_d    = src_c + CW'(1);
            we_c     = 1'b1;
            if (src_c == '0) begin
              wd_c    = bits_c;
              state_d = StDone;
            end else begin
              re_c    = 1'b1;
              state_d = StWalk;
            end
          end
        end
      end
      StWalk: begin
        // rdata_q holds the column just left of tgt_q
        if ((rdata_q & bits_q) == '0) begin
          tgt_d = tgt_m1;
          acc_d = rdata_q;
          if (tgt_m1 == '0) begin
            we_c    = 1'b1;
            wa_c    = '0;
            wd_c    = rdata_q | bits_q;
            state_d = StDone;
          end else begin
            re_c = 1'b1;
            ra_c = tgt_m2[AW-1:0];
          end
        end else begin
          we_c    = 1'b1;
          wa_c    = tgt_q[AW-1:0];
          wd_c    = acc_q | bits_q;
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_c) begin
      mem[wa_c] <= wd_c;
    end
    if (re_c) begin
      rdata_q <= mem[ra_c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    tgt_q    <= tgt_d;
    bits_q   <= bits_d;
    acc_q    <= acc_d;
    status_q <= status_d;
  end

  assign src_ext   = {{OutColW{1'b0}}, src_q};
  assign tgt_ext   = {{OutColW{1'b0}}, tgt_q};
  assign shift_ext = {{OutColW{1'b0}}, CW'(src_q - tgt_q)};

  assign in_ready_o           = (state_q == StIdle);
  assign res_valid_o          = (state_q == StDone);
  assign res_o.source_column  = src_ext[OutColW-1:0];
  assign res_o.target_column  = tgt_ext[OutColW-1:0];
  assign res_o.shift_cols     = shift_ext[OutColW-1:0];
  assign res_o.status         = status_q;

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_c && re_c) |-> (wa_c != ra_c))
    else $error("occupancy write and read hit the same column");

  a_walk_above_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (tgt_q != '0) && (tgt_q <= src_q))
    else $error("walk left its column range");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCount)
    else $error("column counter beyond capacity");

  a_first_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && first_column_i) |=> (cnt_q == CW'(1)) && (src_q == '0))
    else $error("new layout did not restart at column zero");

  a_unplaced_no_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (status_q != StatusPlaced)) |-> (tgt_q == src_q))
    else $error("unplaced column reported a shift");

endmodule

// File: design/column_slide_compactor.sv
// Column slide compactor top level: stream ports and output word register.
// Depends on csc_pkg and csc_engine.
//
// Each input word carries one column's inclusive row interval, in column order;
// tuser marks the first column of a new layout. The block slides the interval
// left past earlier columns, in turn, while their occupied rows are disjoint from it and
// returns one output word per input word: source column, target column, shift
// and status (placed, reversed interval, capacity exceeded). A placed item in a
// column above zero goes from idle to the walk state, which reads R columns
// (the shift plus one when a conflict stops the walk, the shift alone when it
// reaches column zero; at most MAX_COLUMNS-1), one column read per cycle over
// the occupancy memory's single read port; reversed, over-capacity and column-zero
// items go from idle straight to done. Output back-pressure holds them in done.
// The next word is accepted while a finished word waits at the output. A new
// layout needs no clearing pass: the column counter bounds the columns read.
module column_slide_compactor #(
  parameter int MAX_COLUMNS = csc_pkg::MaxColumnsDef,
  parameter int MAX_ROWS    = csc_pkg::MaxRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // min_row[5:0], max_row[11:6], zero pad
  input  logic [0:0]  s_axis_tuser_i,   // first_column[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // source_column[7:0], target_column[15:8],
                                        // shift_cols[23:16]
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);
  import csc_pkg::*;

  logic        res_valid, res_ready;
  csc_result_t res;
  logic        m_valid_q, m_valid_d;
  logic [23:0] m_data_q;
  logic [1:0]  m_user_q;

  csc_engine #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .first_column_i (s_axis_tuser_i[0]),
    .min_row_i      (s_axis_tdata_i[5:0]),
    .max_row_i      (s_axis_tdata_i[11:6]),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= {res.shift_cols, res.target_column, res.source_column};
      m_user_q <= res.status;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule
